FILE: src/gcfe_pkg.sv
// Shared types, constants and the CRC-16 byte update for the gimbal control frame encoder.
// No dependencies; used by gcfe_serializer, gimbal_control_frame_encoder_top and gcfe_checker.
package gcfe_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 8;

  // Frame layout
  localparam logic [POS_W-1:0] POS_START   = 4'd0;
  localparam logic [POS_W-1:0] POS_LEN     = 4'd1;
  localparam logic [POS_W-1:0] POS_CMD     = 4'd2;
  localparam logic [POS_W-1:0] POS_PITCH_L = 4'd3;
  localparam logic [POS_W-1:0] POS_PITCH_H = 4'd4;
  localparam logic [POS_W-1:0] POS_YAW_L   = 4'd5;
  localparam logic [POS_W-1:0] POS_YAW_H   = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC_L   = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC_H   = 4'd8;

  localparam logic [BYTE_W-1:0] LEN_CODE = 8'd4;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE = 8'd1;

  // Frame load request from the top level to the serializer
  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] command_code;
    logic [CMD_W-1:0]  pitch;
    logic [CMD_W-1:0]  yaw;
  } frame_req_t;

  // One byte through the CRC, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

FILE: src/gcfe_serializer.sv
// Frame serializer: emits the nine frame bytes one per cycle, folding the CRC in as it goes.
// Depends on gcfe_pkg.
module gcfe_serializer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gcfe_pkg::frame_req_t       req,
  output logic                       can_load,
  output logic                       out_valid,
  output logic [gcfe_pkg::BYTE_W-1:0] out_tx_byte,
  output logic [gcfe_pkg::POS_W-1:0]  out_byte_position,
  output logic                       out_frame_end
);

  logic                        active_r, active_nxt;
  logic [gcfe_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [gcfe_pkg::BYTE_W-1:0] start_r, cmd_r;
  logic [gcfe_pkg::CMD_W-1:0]  pitch_r, yaw_r;
  logic [gcfe_pkg::BYTE_W-1:0] cur_byte;

  logic                        out_valid_r;
  logic [gcfe_pkg::BYTE_W-1:0] out_byte_r;
  logic [gcfe_pkg::POS_W-1:0]  out_pos_r;
  logic                        out_end_r;

  // A new frame may start when idle or on the last byte of the current one
  assign can_load = !active_r || (pos_r == gcfe_pkg::POS_CRC_H);

  // Byte mux for the current position
  always_comb begin
    case (pos_r)
      gcfe_pkg::POS_START:   cur_byte = start_r;
      gcfe_pkg::POS_LEN:     cur_byte = gcfe_pkg::LEN_CODE;
      gcfe_pkg::POS_CMD:     cur_byte = cmd_r;
      gcfe_pkg::POS_PITCH_L: cur_byte = pitch_r[7:0];
      gcfe_pkg::POS_PITCH_H: cur_byte = pitch_r[15:8];
      gcfe_pkg::POS_YAW_L:   cur_byte = yaw_r[7:0];
      gcfe_pkg::POS_YAW_H:   cur_byte = yaw_r[15:8];
      gcfe_pkg::POS_CRC_L:   cur_byte = crc_r[7:0];
      gcfe_pkg::POS_CRC_H:   cur_byte = crc_r[15:8];
      default:               cur_byte = '0;
    endcase
  end

  // Sequencing and running CRC
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    if (req.load && can_load) begin
      active_nxt = 1'b1;
      pos_nxt    = gcfe_pkg::POS_START;
      crc_nxt    = gcfe_pkg::CRC_INIT;
    end else if (active_r) begin
      pos_nxt = pos_r + 4'd1;
      if (pos_r == gcfe_pkg::POS_CRC_H) begin
        active_nxt = 1'b0;
      end
      if (pos_r < gcfe_pkg::POS_CRC_L) begin
        crc_nxt = gcfe_pkg::crc16_byte(crc_r, cur_byte);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= active_r;
    end
  end

  // Payload: frame fields, CRC and result register
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (req.load && can_load) begin
      start_r <= req.start_byte;
      cmd_r   <= req.command_code;
      pitch_r <= req.pitch;
      yaw_r   <= req.yaw;
    end
    out_byte_r <= cur_byte;
    out_pos_r  <= pos_r;
    out_end_r  <= active_r && (pos_r == gcfe_pkg::POS_CRC_H);
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_end     = out_valid_r && out_end_r;

endmodule

FILE: src/gimbal_control_frame_encoder_top.sv
// Gimbal control frame encoder, top level: command input, configuration registers,
// one-deep command holding register. Depends on gcfe_pkg and gcfe_serializer.
//
// Usage:
//   Command channel: a pitch/yaw pair is transferred at a rising edge with start high
//   and busy low. Each command turns into one nine-byte frame: start byte, length 4,
//   command code, pitch LE, yaw LE, CRC-16/CCITT-FALSE over the first seven bytes LE.
//   Result channel: out_valid strobes each byte for one cycle with its position;
//   out_frame_end marks the CRC high byte. The receiver takes every byte as shown.
//   When the serializer is idle, a command goes from the holding register into the
//   serializer's position register, then its output register; the nine bytes follow in
//   consecutive cycles. The one-byte-per-cycle serializer sets the frame rate.
//   A holding register takes the next command while the current frame is still
//   going out, so back-to-back frames leave with no gap.
//   Configuration: cfg_ready is always high; index 0 is the start byte, index 1 the
//   command code, other indexes are dropped. Write only while the block is idle.
//   Reset (synchronous, rst_n low): holding register and serializer go empty,
//   both configuration registers read 0, no output strobes.
module gimbal_control_frame_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [gcfe_pkg::CMD_W-1:0] in_pitch_cdeg,
  input  logic signed [gcfe_pkg::CMD_W-1:0] in_yaw_cdeg,
  // result channel
  output logic                          out_valid,
  output logic [gcfe_pkg::BYTE_W-1:0]   out_tx_byte,
  output logic [gcfe_pkg::POS_W-1:0]    out_byte_position,
  output logic                          out_frame_end,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcfe_pkg::BYTE_W-1:0]   cfg_data
);

  logic [gcfe_pkg::BYTE_W-1:0] start_byte_r, command_code_r;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [gcfe_pkg::CMD_W-1:0]  pend_pitch_r, pend_yaw_r;
  logic                        in_xfer;
  logic                        can_load;
  gcfe_pkg::frame_req_t        req;

  assign cfg_ready = 1'b1;
  assign busy      = pend_valid_r;
  assign in_xfer   = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= '0;
      command_code_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcfe_pkg::CFG_START_BYTE:   start_byte_r   <= cfg_data;
        gcfe_pkg::CFG_COMMAND_CODE: command_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Holding register: filled on transfer, emptied when the serializer takes it
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (pend_valid_r && can_load) begin
      pend_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_pitch_r <= in_pitch_cdeg;
      pend_yaw_r   <= in_yaw_cdeg;
    end
  end

  // Load request toward the serializer
  always_comb begin
    req.load         = pend_valid_r;
    req.start_byte   = start_byte_r;
    req.command_code = command_code_r;
    req.pitch        = pend_pitch_r;
    req.yaw          = pend_yaw_r;
  end

  gcfe_serializer u_ser (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_tx_byte       (out_tx_byte),
    .out_byte_position (out_byte_position),
    .out_frame_end     (out_frame_end)
  );

endmodule

FILE: src/gcfe_checker.sv
// Port-level checker for the gimbal control frame encoder, bound to the top level.
// Depends on gcfe_pkg and gimbal_control_frame_encoder_top.
module gcfe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [gcfe_pkg::POS_W-1:0]    out_byte_position,
  input logic                          out_frame_end
);

  // Frame end only on the CRC high byte
  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> (out_valid && out_byte_position == gcfe_pkg::POS_CRC_H))
    else $error("frame_end off the last byte");

  // Bytes of a frame go out in consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_position != gcfe_pkg::POS_CRC_H) |=>
    (out_valid && out_byte_position == $past(out_byte_position) + 4'd1))
    else $error("frame byte missing or out of order");

  // A burst starts at the first byte
  a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_byte_position == gcfe_pkg::POS_START))
    else $error("frame started mid-way");

  // A transferred command is held, so busy rises next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer not held");

endmodule

bind gimbal_control_frame_encoder_top gcfe_checker u_gcfe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_byte_position (out_byte_position),
  .out_frame_end     (out_frame_end)
);
